/* hw/rtl/rvde_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rvde_pkg;

    localparam int unsigned XLEN = 32;

    // RV32I major opcodes
    localparam logic [6:0] OPC_OP     = 7'd51;
    localparam logic [6:0] OPC_OPIMM  = 7'd19;
    localparam logic [6:0] OPC_LOAD   = 7'd3;
    localparam logic [6:0] OPC_JALR   = 7'd103;
    localparam logic [6:0] OPC_STORE  = 7'd35;
    localparam logic [6:0] OPC_BRANCH = 7'd99;
    localparam logic [6:0] OPC_LUI    = 7'd55;
    localparam logic [6:0] OPC_AUIPC  = 7'd23;
    localparam logic [6:0] OPC_JAL    = 7'd111;

    // funct3 codes for OP / OP-IMM
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    // funct3 codes for branches
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;

    // funct3 codes for loads, stores and jalr
    localparam logic [2:0] F3_LD_RSV3 = 3'd3;
    localparam logic [2:0] F3_LD_RSV6 = 3'd6;
    localparam logic [2:0] F3_LD_RSV7 = 3'd7;
    localparam logic [2:0] F3_ST_MAX  = 3'd2;
    localparam logic [2:0] F3_JALR    = 3'd0;

    localparam logic [6:0] F7_BASE = 7'd0;
    localparam logic [6:0] F7_ALT  = 7'd32;

    localparam logic [XLEN-1:0] INSN_BYTES = 32'd4;

    typedef enum logic [1:0] {
        SRC_NONE = 2'd0,
        SRC_PC4  = 2'd1,
        SRC_MEM  = 2'd2,
        SRC_ALU  = 2'd3
    } result_src_t;

    typedef enum logic [1:0] {
        MEM_NONE  = 2'd0,
        MEM_LOAD  = 2'd1,
        MEM_STORE = 2'd2
    } mem_kind_t;

    typedef enum logic [3:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_XOR,
        ALU_OR,
        ALU_AND,
        ALU_SLL,
        ALU_SRL,
        ALU_SRA,
        ALU_SLT
    } alu_op_t;

    typedef struct packed {
        logic              illegal;
        logic [XLEN-1:0]   next_pc;
        logic              branch_taken;
        mem_kind_t         mem_access;
        result_src_t       result_source;
        logic              reg_write;
        logic [4:0]        dest_reg;
        logic [XLEN-1:0]   alu_result;
    } exec_result_t;

    typedef struct packed {
        logic [XLEN-1:0] rs2_value;
        logic [XLEN-1:0] rs1_value;
        logic [XLEN-1:0] pc;
        logic [XLEN-1:0] instruction;
    } exec_item_t;

endpackage

`default_nettype wire

/* hw/rtl/rv32i_decode_execute.sv */
// RV32I decode and execute stage.
// Input stream (s_*): one word per instruction, holding the instruction,
// its pc and both source register values. Output stream (m_*): one word per
// instruction with the ALU result or effective address, destination
// register, write enable, result source, memory access kind, branch
// decision, next pc and an illegal flag.
// Two register stages: the accepted word lands in an input register, the
// decode/ALU logic feeds a result register that drives m_*. m_tvalid rises
// once the word has moved from the input register into the result register;
// throughput is one word per cycle while m_tready stays high, set by the
// single pass through the decoder, ALU and target adders.
// When the receiver stalls, the result register holds and the input
// register fills behind it; s_tready drops only once both are full, and the
// stream resumes at full rate as soon as m_tready returns.
// Reset empties both stages; no word is in flight afterwards.
`timescale 1ns / 1ps
`default_nettype none

module rv32i_decode_execute
(
    input  wire         clk,
    input  wire         rst_n,

    input  wire         s_tvalid,
    output logic        s_tready,
    // instruction[31:0], pc[63:32], rs1_value[95:64], rs2_value[127:96]
    input  wire [127:0] s_tdata,

    output logic        m_tvalid,
    input  wire         m_tready,
    // alu_result[31:0], dest_reg[36:32], reg_write[37], result_source[39:38],
    // mem_access[41:40], branch_taken[42], next_pc[74:43], illegal[75], zero pad
    output logic [79:0] m_tdata
);

    logic                    in_valid_reg;
    logic                    in_valid_next;
    rvde_pkg::exec_item_t    in_item_reg;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    rvde_pkg::exec_result_t  out_result_reg;
    rvde_pkg::exec_result_t  exec_result;

    logic                    out_load;
    logic                    in_load;

    // result stage frees up when empty or when its word is taken this cycle
    assign out_load = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || out_load;
    assign in_load  = s_tvalid && s_tready;

    rvde_exec u_exec
    (
        .item   (in_item_reg),
        .result (exec_result)
    );

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = in_valid_reg;
        if (s_tready)
            in_valid_next = s_tvalid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
            in_item_reg <= s_tdata;
        if (out_load && in_valid_reg)
            out_result_reg <= exec_result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_result_reg};

endmodule

`default_nettype wire

/* hw/rtl/rvde_alu.sv */
`timescale 1ns / 1ps
`default_nettype none

module rvde_alu
(
    input  wire rvde_pkg::alu_op_t              op,
    input  wire logic [rvde_pkg::XLEN-1:0]      a,
    input  wire logic [rvde_pkg::XLEN-1:0]      b,
    output logic      [rvde_pkg::XLEN-1:0]      y
);

    logic [4:0] shamt;

    assign shamt = b[4:0];

    always_comb
    begin
        unique case (op)
            rvde_pkg::ALU_ADD: y = a + b;
            rvde_pkg::ALU_SUB: y = a - b;
            rvde_pkg::ALU_XOR: y = a ^ b;
            rvde_pkg::ALU_OR:  y = a | b;
            rvde_pkg::ALU_AND: y = a & b;
            rvde_pkg::ALU_SLL: y = a << shamt;
            rvde_pkg::ALU_SRL: y = a >> shamt;
            rvde_pkg::ALU_SRA: y = $unsigned($signed(a) >>> shamt);
            rvde_pkg::ALU_SLT: y = {{(rvde_pkg::XLEN-1){1'b0}}, ($signed(a) < $signed(b))};
            default:           y = '0;
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/rvde_exec.sv */
`timescale 1ns / 1ps
`default_nettype none

module rvde_exec
(
    input  wire rvde_pkg::exec_item_t   item,
    output rvde_pkg::exec_result_t      result
);

    localparam int unsigned W = rvde_pkg::XLEN;

    logic [31:0]   ins;
    logic [W-1:0]  pc;
    logic [W-1:0]  rs1;
    logic [W-1:0]  rs2;
    logic [6:0]    opc;
    logic [4:0]    rd;
    logic [2:0]    f3;
    logic [6:0]    f7;
    logic [W-1:0]  imm_i;
    logic [W-1:0]  imm_s;
    logic [W-1:0]  imm_b;
    logic [W-1:0]  imm_u;
    logic [W-1:0]  imm_j;
    logic [W-1:0]  pc_plus4;
    logic [W-1:0]  jalr_sum;
    logic          src_eq;
    logic          src_lt;

    rvde_pkg::alu_op_t alu_op;
    logic [W-1:0]      alu_b;
    logic [W-1:0]      alu_y;

    logic                      ok;
    logic                      cond;
    logic [W-1:0]              res;
    logic [W-1:0]              npc;
    logic                      wr;
    logic                      taken;
    rvde_pkg::result_src_t     src;
    rvde_pkg::mem_kind_t       mem;

    assign ins = item.instruction;
    assign pc  = item.pc;
    assign rs1 = item.rs1_value;
    assign rs2 = item.rs2_value;
    assign opc = ins[6:0];
    assign rd  = ins[11:7];
    assign f3  = ins[14:12];
    assign f7  = ins[31:25];

    assign imm_i = {{20{ins[31]}}, ins[31:20]};
    assign imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
    assign imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
    assign imm_u = {ins[31:12], 12'b0};
    assign imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};

    assign pc_plus4 = pc + rvde_pkg::INSN_BYTES;
    assign jalr_sum = rs1 + imm_i;
    assign src_eq   = (rs1 == rs2);
    assign src_lt   = ($signed(rs1) < $signed(rs2));

    rvde_alu u_alu
    (
        .op (alu_op),
        .a  (rs1),
        .b  (alu_b),
        .y  (alu_y)
    );

    always_comb
    begin
        ok     = 1'b1;
        cond   = 1'b0;
        res    = '0;
        npc    = pc_plus4;
        wr     = 1'b0;
        taken  = 1'b0;
        src    = rvde_pkg::SRC_NONE;
        mem    = rvde_pkg::MEM_NONE;
        alu_op = rvde_pkg::ALU_ADD;
        alu_b  = rs2;

        unique case (opc)
            rvde_pkg::OPC_OP:
            begin
                wr = 1'b1;
                src = rvde_pkg::SRC_ALU;
                res = alu_y;
                unique case (f3)
                    rvde_pkg::F3_ADD:
                    begin
                        if (f7 == rvde_pkg::F7_ALT)
                            alu_op = rvde_pkg::ALU_SUB;
                        else
                            ok = (f7 == rvde_pkg::F7_BASE);
                    end
                    rvde_pkg::F3_XOR:
                    begin
                        alu_op = rvde_pkg::ALU_XOR;
                        ok = (f7 == rvde_pkg::F7_BASE);
                    end
                    rvde_pkg::F3_OR:
                    begin
                        alu_op = rvde_pkg::ALU_OR;
                        ok = (f7 == rvde_pkg::F7_BASE);
                    end
                    rvde_pkg::F3_AND:
                    begin
                        alu_op = rvde_pkg::ALU_AND;
                        ok = (f7 == rvde_pkg::F7_BASE);
                    end
                    rvde_pkg::F3_SLT:
                    begin
                        alu_op = rvde_pkg::ALU_SLT;
                        ok = (f7 == rvde_pkg::F7_BASE);
                    end
                    rvde_pkg::F3_SLL:
                    begin
                        alu_op = rvde_pkg::ALU_SLL;
                        ok = (f7 == rvde_pkg::F7_BASE);
                    end
                    rvde_pkg::F3_SR:
                    begin
                        if (f7 == rvde_pkg::F7_ALT)
                            alu_op = rvde_pkg::ALU_SRA;
                        else
                        begin
                            alu_op = rvde_pkg::ALU_SRL;
                            ok = (f7 == rvde_pkg::F7_BASE);
                        end
                    end
                    default: ok = 1'b0;   // sltu
                endcase
            end
            rvde_pkg::OPC_OPIMM:
            begin
                wr = 1'b1;
                src = rvde_pkg::SRC_ALU;
                res = alu_y;
                // shifts only look at imm_i[4:0], so imm_i serves as shamt too
                alu_b = imm_i;
                unique case (f3)
                    rvde_pkg::F3_ADD: alu_op = rvde_pkg::ALU_ADD;
                    rvde_pkg::F3_XOR: alu_op = rvde_pkg::ALU_XOR;
                    rvde_pkg::F3_OR:  alu_op = rvde_pkg::ALU_OR;
                    rvde_pkg::F3_AND: alu_op = rvde_pkg::ALU_AND;
                    rvde_pkg::F3_SLT: alu_op = rvde_pkg::ALU_SLT;
                    rvde_pkg::F3_SLL:
                    begin
                        alu_op = rvde_pkg::ALU_SLL;
                        ok = (f7 == rvde_pkg::F7_BASE);
                    end
                    rvde_pkg::F3_SR:
                    begin
                        if (f7 == rvde_pkg::F7_ALT)
                            alu_op = rvde_pkg::ALU_SRA;
                        else
                        begin
                            alu_op = rvde_pkg::ALU_SRL;
                            ok = (f7 == rvde_pkg::F7_BASE);
                        end
                    end
                    default: ok = 1'b0;   // sltiu
                endcase
            end
            rvde_pkg::OPC_LOAD:
            begin
                ok  = (f3 != rvde_pkg::F3_LD_RSV3) && (f3 != rvde_pkg::F3_LD_RSV6)
                      && (f3 != rvde_pkg::F3_LD_RSV7);
                res = jalr_sum;
                wr  = 1'b1;
                src = rvde_pkg::SRC_MEM;
                mem = rvde_pkg::MEM_LOAD;
            end
            rvde_pkg::OPC_STORE:
            begin
                ok  = (f3 <= rvde_pkg::F3_ST_MAX);
                res = rs1 + imm_s;
                mem = rvde_pkg::MEM_STORE;
            end
            rvde_pkg::OPC_BRANCH:
            begin
                unique case (f3)
                    rvde_pkg::F3_BEQ: cond = src_eq;
                    rvde_pkg::F3_BNE: cond = !src_eq;
                    rvde_pkg::F3_BLT: cond = src_lt;
                    rvde_pkg::F3_BGE: cond = !src_lt;
                    default:          ok = 1'b0;
                endcase
                if (cond)
                begin
                    taken = 1'b1;
                    npc   = pc + imm_b;
                end
            end
            rvde_pkg::OPC_LUI:
            begin
                res = imm_u;
                wr  = 1'b1;
                src = rvde_pkg::SRC_ALU;
            end
            rvde_pkg::OPC_AUIPC:
            begin
                res = pc + imm_u;
                wr  = 1'b1;
                src = rvde_pkg::SRC_ALU;
            end
            rvde_pkg::OPC_JAL:
            begin
                res   = pc_plus4;
                wr    = 1'b1;
                src   = rvde_pkg::SRC_PC4;
                taken = 1'b1;
                npc   = pc + imm_j;
            end
            rvde_pkg::OPC_JALR:
            begin
                ok    = (f3 == rvde_pkg::F3_JALR);
                res   = pc_plus4;
                wr    = 1'b1;
                src   = rvde_pkg::SRC_PC4;
                taken = 1'b1;
                npc   = {jalr_sum[W-1:1], 1'b0};
            end
            default: ok = 1'b0;
        endcase

        if (!ok)
        begin
            res   = '0;
            wr    = 1'b0;
            src   = rvde_pkg::SRC_NONE;
            mem   = rvde_pkg::MEM_NONE;
            taken = 1'b0;
            npc   = pc_plus4;
        end

        result.alu_result    = res;
        result.dest_reg      = wr ? rd : 5'd0;
        result.reg_write     = wr;
        result.result_source = src;
        result.mem_access    = mem;
        result.branch_taken  = taken;
        result.next_pc       = npc;
        result.illegal       = !ok;
    end

endmodule

`default_nettype wire
